// ----- design/tdp_pkg.sv -----
// Shared types, constants and the per-lane ternary term function
// for the ternary weight dot product unit. No dependencies.
package tdp_pkg;

    localparam int ACT_W     = 8;   // int8 activation
    localparam int ACTS      = 4;   // activations per request
    localparam int LANES     = 8;   // dot_row ports
    localparam int WBYTE_W   = 8;   // packed weight byte per lane
    localparam int CODE_W    = 2;
    localparam int PROD_W    = 9;   // one (c-1)*a product
    localparam int TERM_W    = 11;  // sum of four products
    localparam int SUM_W     = 24;  // wrapping accumulator
    localparam int ROWS_W    = 4;   // active_rows register
    localparam logic [ROWS_W-1:0] ROWS_RESET = 4'd8;

    // 2-bit weight codes
    localparam logic [CODE_W-1:0] CODE_NEG  = 2'd0;  // -1
    localparam logic [CODE_W-1:0] CODE_ZERO = 2'd1;  //  0
    localparam logic [CODE_W-1:0] CODE_POS  = 2'd2;  // +1
    localparam logic [CODE_W-1:0] CODE_DBL  = 2'd3;  // +2

    typedef logic signed [ACT_W-1:0]  t_act;
    typedef t_act [ACTS-1:0]          t_act_vec;
    typedef logic [WBYTE_W-1:0]       t_wbyte;
    typedef logic [SUM_W-1:0]         t_sum;
    typedef logic signed [TERM_W-1:0] t_term;

    // Per-lane control from the top level
    typedef struct packed {
        logic step;   // request consumed this cycle
        logic last;   // it closes the vector: clear after use
    } t_lane_ctl;

    // Bits 7:6 pair with act[0], down to bits 1:0 with act[3]
    function automatic t_term lane_term(input t_wbyte wb, input t_act_vec act);
        logic [CODE_W-1:0]        code;
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] prod;
        t_term                    acc;
        acc = '0;
        for (int q = 0; q < ACTS; q++) begin
            code = wb[WBYTE_W-1-CODE_W*q -: CODE_W];
            a    = {act[q][ACT_W-1], act[q]};
            case (code)
                CODE_NEG:  prod = -a;
                CODE_ZERO: prod = '0;
                CODE_POS:  prod = a;
                default:   prod = a <<< 1;
            endcase
            acc = acc + {{(TERM_W-PROD_W){prod[PROD_W-1]}}, prod};
        end
        return acc;
    endfunction

endpackage

// ----- design/tdp_lane.sv -----
// One weight row: ternary term of four activations plus a 24-bit
// wrapping accumulator. Depends on tdp_pkg.
module tdp_lane
    import tdp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  t_wbyte    i_wbyte,
    input  t_act_vec  i_act,
    output t_sum      o_sum_next
);

    t_sum  r_acc;
    t_sum  n_acc;
    t_term term;

    assign term       = lane_term(i_wbyte, i_act);
    assign o_sum_next = r_acc + {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.step) begin
            n_acc = i_ctl.last ? '0 : o_sum_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

// ----- design/tdp_len_count.sv -----
// Vector length counter: saturates one past the limit and flags overflow.
// Depends on tdp_pkg.
module tdp_len_count
    import tdp_pkg::*;
#(
    parameter int MAX_LENGTH = 16384
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    output logic      o_overflow_next
);

    localparam int ITEM_LIMIT = MAX_LENGTH / 4;
    localparam int CNT_W      = $clog2(ITEM_LIMIT + 2);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(ITEM_LIMIT);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] n_cnt;

    // count includes the current request; holds at limit + 1
    assign cnt_inc         = (r_cnt <= LIMIT) ? r_cnt + 1'b1 : r_cnt;
    assign o_overflow_next = cnt_inc > LIMIT;

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.step) begin
            n_cnt = i_ctl.last ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- design/ternary_weight_dot_product_unit.sv -----
// Top level of the ternary weight dot product unit: input register, up to
// eight accumulating lanes (ROW_LANES), length counter and result register.
// Depends on tdp_pkg, tdp_lane and tdp_len_count.
// Usage
//   Input channel (i_in_valid / o_in_ready): each request carries four int8
//   activations and one packed weight byte per row (byte k for row k). The
//   request with i_row_end high closes the vector.
//   Output channel (o_out_valid / i_out_ready): one result per closed vector,
//   eight 24-bit signed sums plus the overflow flag (more than MAX_LENGTH/4
//   requests in the vector). Rows at or above active_rows or ROW_LANES read 0.
//   Config: i_cfg_wr_en / i_cfg_wr_data write active_rows (reset 8); write
//   only while the unit is idle.
// Timing
//   A request is accepted into the input register and, once consumed, is
//   summed into the accumulators; a row_end request instead loads its
//   total into the result register, which offers it, and clears the
//   accumulators. One request per cycle unless a row_end request waits.
// Stall
//   While a result waits, non-final requests keep flowing into the
//   accumulators; only the next row_end request waits in the input register.
// Reset
//   Synchronous, active low: empties both registers, clears the sums and
//   the length counter, and sets active_rows to 8.
module ternary_weight_dot_product_unit
    import tdp_pkg::*;
#(
    parameter int MAX_LENGTH = 16384,
    parameter int ROW_LANES  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [ROWS_W-1:0]  i_cfg_wr_data,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [7:0]  i_act_q0,
    input  logic signed [7:0]  i_act_q1,
    input  logic signed [7:0]  i_act_q2,
    input  logic signed [7:0]  i_act_q3,
    input  logic [63:0]        i_weight_bytes,
    input  logic               i_row_end,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_dot_row0,
    output logic signed [23:0] o_dot_row1,
    output logic signed [23:0] o_dot_row2,
    output logic signed [23:0] o_dot_row3,
    output logic signed [23:0] o_dot_row4,
    output logic signed [23:0] o_dot_row5,
    output logic signed [23:0] o_dot_row6,
    output logic signed [23:0] o_dot_row7,
    output logic               o_overflow
);

    // ---- configuration register ----
    logic [ROWS_W-1:0] r_active_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_rows <= ROWS_RESET;
        end else if (i_cfg_wr_en) begin
            r_active_rows <= i_cfg_wr_data;
        end
    end

    // ---- input register ----
    logic                     r_in_vld;
    t_act_vec                 r_act;
    logic [LANES*WBYTE_W-1:0] r_wbytes;
    logic                     r_last;

    logic      out_free;
    logic      consume;
    logic      accept;
    t_lane_ctl lane_ctl;

    assign out_free   = !o_out_valid || i_out_ready;
    // a final request also needs room in the result register
    assign consume    = r_in_vld && (!r_last || out_free);
    assign o_in_ready = !r_in_vld || consume;
    assign accept     = i_in_valid && o_in_ready;

    assign lane_ctl.step = consume;
    assign lane_ctl.last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act    <= {i_act_q3, i_act_q2, i_act_q1, i_act_q0};
            r_wbytes <= i_weight_bytes;
            r_last   <= i_row_end;
        end
    end

    // ---- lanes ----
    t_sum sum_next [LANES];
    logic ovf_next;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        if (k < ROW_LANES) begin : g_live
            tdp_lane u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (lane_ctl),
                .i_wbyte    (r_wbytes[k*WBYTE_W +: WBYTE_W]),
                .i_act      (r_act),
                .o_sum_next (sum_next[k])
            );
        end else begin : g_absent
            // rows beyond ROW_LANES have no accumulator and read zero
            assign sum_next[k] = '0;
        end
    end

    tdp_len_count #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_len (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (lane_ctl),
        .o_overflow_next (ovf_next)
    );

    // ---- result register ----
    logic r_out_vld;
    t_sum r_dot [LANES];
    logic r_ovf;
    logic load;

    assign load = consume && r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < LANES; k++) begin
                r_dot[k] <= (ROWS_W'(k) < r_active_rows) ? sum_next[k] : '0;
            end
            r_ovf <= ovf_next;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_dot_row0  = r_dot[0];
    assign o_dot_row1  = r_dot[1];
    assign o_dot_row2  = r_dot[2];
    assign o_dot_row3  = r_dot[3];
    assign o_dot_row4  = r_dot[4];
    assign o_dot_row5  = r_dot[5];
    assign o_dot_row6  = r_dot[6];
    assign o_dot_row7  = r_dot[7];
    assign o_overflow  = r_ovf;

endmodule

// ----- design/tdp_checker.sv -----
// Port-level checks for ternary_weight_dot_product_unit, attached by bind.
// Depends on tdp_pkg.
module tdp_checker
    import tdp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_wr_en,
    input logic [ROWS_W-1:0]  i_cfg_wr_data,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [23:0] o_dot_row0,
    input logic signed [23:0] o_dot_row7,
    input logic               o_overflow
);

    // mirror of the row count register
    logic [ROWS_W-1:0] r_rows_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_seen <= ROWS_RESET;
        end else if (i_cfg_wr_en) begin
            r_rows_seen <= i_cfg_wr_data;
        end
    end

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_dot_row0) && $stable(o_dot_row7) && $stable(o_overflow))
        else $error("result changed while stalled");

    // with room downstream the unit never back-pressures
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("request refused with free result slot");

    // masked rows read zero
    a_row_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_rows_seen < 4'd8) |-> o_dot_row7 == 24'sd0)
        else $error("inactive row 7 not zero");

    a_row_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_rows_seen == 4'd0) |-> o_dot_row0 == 24'sd0)
        else $error("row 0 not zero with no active rows");

endmodule

bind ternary_weight_dot_product_unit tdp_checker u_tdp_checker (.*);
